// ===== src/touch_point_event_filter_unit_defines.svh =====
// Assertion macros for the touch point event filter.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TOUCH_POINT_EVENT_FILTER_UNIT_DEFINES_SVH
`define TOUCH_POINT_EVENT_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define TPEF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define TPEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPEF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define TPEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/tpef_pkg.sv =====
// Shared types, constants and microcode table for the touch point event filter.
// No dependencies; used by the divider and the top level.
`timescale 1ns / 1ps

package tpef_pkg;

    localparam int SAMPLES_PER_POINT = 32;
    localparam int ADC_BITS          = 12;

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 17;
    localparam int SCALE_W  = 16;
    localparam int SIZE_W   = 13;
    localparam int COORD_W  = 12;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W    = (SAMPLES_PER_POINT > 1) ? $clog2(SAMPLES_PER_POINT) : 1;
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int PC_W     = 3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_POINT - 1);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(4096);

    // Event codes
    localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
    localparam logic [KIND_W-1:0] EV_DRAG = 2'd1;
    localparam logic [KIND_W-1:0] EV_UP   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_X    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL_Y    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

    // Register reset values
    localparam logic [SCALE_W-1:0] RST_SCALE_X  = 16'd258;
    localparam logic [SUM_W-1:0]   RST_OFFSET_X = 17'd3390;
    localparam logic [SCALE_W-1:0] RST_SCALE_Y  = 16'd423;
    localparam logic [SUM_W-1:0]   RST_OFFSET_Y = 17'd7670;
    localparam logic [SUM_W-1:0]   RST_TOL_X    = 17'd100;
    localparam logic [SUM_W-1:0]   RST_TOL_Y    = 17'd100;
    localparam logic [SIZE_W-1:0]  RST_WIDTH    = 13'd480;
    localparam logic [SIZE_W-1:0]  RST_HEIGHT   = 13'd272;

    // Microcode operations
    localparam logic [2:0] OP_WAIT   = 3'd0;
    localparam logic [2:0] OP_CMP    = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_FINISH = 3'd3;
    localparam logic [2:0] OP_EMIT   = 3'd4;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Program steps
    localparam logic [PC_W-1:0] STEP_WAIT     = 3'd0;
    localparam logic [PC_W-1:0] STEP_CMP      = 3'd1;
    localparam logic [PC_W-1:0] STEP_START_X  = 3'd2;
    localparam logic [PC_W-1:0] STEP_FINISH_X = 3'd3;
    localparam logic [PC_W-1:0] STEP_START_Y  = 3'd4;
    localparam logic [PC_W-1:0] STEP_FINISH_Y = 3'd5;
    localparam logic [PC_W-1:0] STEP_EMIT     = 3'd6;

    typedef struct packed {
        logic                pen_lifted;
        logic [SAMPLE_W-1:0] sample_x;
        logic [SAMPLE_W-1:0] sample_y;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
    } t_out_item;

    // One control word: operation, axis for the datapath muxes, jump target.
    typedef struct packed {
        logic [2:0]      op;
        logic            axis;
        logic [PC_W-1:0] jmp;
    } t_uword;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            STEP_WAIT:     w = '{op: OP_WAIT,   axis: AXIS_X, jmp: STEP_WAIT};
            STEP_CMP:      w = '{op: OP_CMP,    axis: AXIS_X, jmp: STEP_WAIT};
            STEP_START_X:  w = '{op: OP_START,  axis: AXIS_X, jmp: STEP_START_Y};
            STEP_FINISH_X: w = '{op: OP_FINISH, axis: AXIS_X, jmp: STEP_FINISH_X};
            STEP_START_Y:  w = '{op: OP_START,  axis: AXIS_Y, jmp: STEP_EMIT};
            STEP_FINISH_Y: w = '{op: OP_FINISH, axis: AXIS_Y, jmp: STEP_FINISH_Y};
            STEP_EMIT:     w = '{op: OP_EMIT,   axis: AXIS_X, jmp: STEP_WAIT};
            default:       w = '{op: OP_WAIT,   axis: AXIS_X, jmp: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== src/tpef_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle; the quotient is SUM_W bits wide.
// Depends on tpef_pkg for widths and the status struct.
`timescale 1ns / 1ps

module tpef_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tpef_pkg::SUM_W-1:0]   i_dividend,
    input  logic [tpef_pkg::SCALE_W-1:0] i_divisor,
    output tpef_pkg::t_div_stat          o_stat,
    output logic [tpef_pkg::SUM_W-1:0]   o_quotient
);

    localparam logic [tpef_pkg::DIV_CNT_W-1:0] DIV_LAST =
        tpef_pkg::DIV_CNT_W'(tpef_pkg::SUM_W - 1);

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [tpef_pkg::DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic [tpef_pkg::SCALE_W-1:0]       r_rem, n_rem;
    logic [tpef_pkg::SCALE_W-1:0]       r_div, n_div;
    logic [tpef_pkg::SUM_W-1:0]         r_quo, n_quo;

    logic [tpef_pkg::SCALE_W:0] w_shift;
    logic [tpef_pkg::SCALE_W:0] w_diff;
    logic                       w_ge;

    assign w_shift = {r_rem, r_quo[tpef_pkg::SUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            // zero scale acts as one
            n_div  = (i_divisor == '0) ? tpef_pkg::SCALE_W'(1) : i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[tpef_pkg::SCALE_W-1:0] : w_shift[tpef_pkg::SCALE_W-1:0];
            n_quo = {r_quo[tpef_pkg::SUM_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_div <= n_div;
        r_quo <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

// ===== src/touch_point_event_filter_unit.sv =====
// Touch point event filter: a sample pair or pen-up is taken while the sequencer waits and
// the output register is free; a pen-up event is valid in the next cycle. Closing a group
// stalls the input for the compare step; if an axis moved, also a start step and a wait on
// the shared divider per moved axis, then the emit step, plus any time the output is held.
// Synchronous active-low reset restores register defaults and clears sequencer, sums and pen state.
// Depends on tpef_pkg, tpef_divider and touch_point_event_filter_unit_defines.svh.
`timescale 1ns / 1ps
`include "touch_point_event_filter_unit_defines.svh"

module touch_point_event_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tpef_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tpef_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpef_pkg::SUM_W-1:0]     i_cfg_data
);

    // configuration
    logic [tpef_pkg::SCALE_W-1:0] r_scale_x, r_scale_y;
    logic [tpef_pkg::SUM_W-1:0]   r_offset_x, r_offset_y, r_tol_x, r_tol_y;
    logic [tpef_pkg::SIZE_W-1:0]  r_width, r_height;

    // sequencer and datapath state
    logic [tpef_pkg::PC_W-1:0]    r_pc, n_pc;
    logic [tpef_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [tpef_pkg::SUM_W-1:0]   r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic [tpef_pkg::SUM_W-1:0]   r_gx, n_gx, r_gy, n_gy;
    logic [tpef_pkg::SUM_W-1:0]   r_last_x, n_last_x, r_last_y, n_last_y;
    logic [tpef_pkg::COORD_W-1:0] r_held_x, n_held_x, r_held_y, n_held_y;
    logic                         r_touching, n_touching;
    logic                         r_move_x, n_move_x, r_move_y, n_move_y;
    logic                         r_out_valid, n_out_valid;
    tpef_pkg::t_out_item          r_out_data, n_out_data;

    tpef_pkg::t_uword             w_uword;
    tpef_pkg::t_div_stat          w_div_stat;
    logic [tpef_pkg::SUM_W-1:0]   w_quotient;
    logic                         w_div_start;
    logic                         w_out_free;
    logic                         w_in_acc;
    logic                         w_emit_load;

    logic [tpef_pkg::SUM_W-1:0]   w_acc_x, w_acc_y;
    logic [tpef_pkg::SUM_W-1:0]   w_dx, w_dy;
    logic [tpef_pkg::SUM_W-1:0]   w_sel_g, w_sel_off, w_dividend;
    logic [tpef_pkg::SCALE_W-1:0] w_sel_scale;
    logic [tpef_pkg::SIZE_W-1:0]  w_sel_size, w_size_eff;
    logic [tpef_pkg::COORD_W-1:0] w_top, w_clamped, w_coord;
    logic                         w_sel_move;

    assign w_uword     = tpef_pkg::ucode(r_pc);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_pc == tpef_pkg::STEP_WAIT) && w_out_free);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= tpef_pkg::RST_SCALE_X;
            r_offset_x <= tpef_pkg::RST_OFFSET_X;
            r_scale_y  <= tpef_pkg::RST_SCALE_Y;
            r_offset_y <= tpef_pkg::RST_OFFSET_Y;
            r_tol_x    <= tpef_pkg::RST_TOL_X;
            r_tol_y    <= tpef_pkg::RST_TOL_Y;
            r_width    <= tpef_pkg::RST_WIDTH;
            r_height   <= tpef_pkg::RST_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tpef_pkg::REG_SCALE_X:  r_scale_x  <= i_cfg_data[tpef_pkg::SCALE_W-1:0];
                tpef_pkg::REG_OFFSET_X: r_offset_x <= i_cfg_data;
                tpef_pkg::REG_SCALE_Y:  r_scale_y  <= i_cfg_data[tpef_pkg::SCALE_W-1:0];
                tpef_pkg::REG_OFFSET_Y: r_offset_y <= i_cfg_data;
                tpef_pkg::REG_TOL_X:    r_tol_x    <= i_cfg_data;
                tpef_pkg::REG_TOL_Y:    r_tol_y    <= i_cfg_data;
                tpef_pkg::REG_WIDTH:    r_width    <= i_cfg_data[tpef_pkg::SIZE_W-1:0];
                tpef_pkg::REG_HEIGHT:   r_height   <= i_cfg_data[tpef_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // accumulators and per-axis change
    assign w_acc_x = r_sum_x + tpef_pkg::SUM_W'(i_in_data.sample_x[tpef_pkg::ADC_BITS-1:0]);
    assign w_acc_y = r_sum_y + tpef_pkg::SUM_W'(i_in_data.sample_y[tpef_pkg::ADC_BITS-1:0]);
    assign w_dx    = (r_gx >= r_last_x) ? (r_gx - r_last_x) : (r_last_x - r_gx);
    assign w_dy    = (r_gy >= r_last_y) ? (r_gy - r_last_y) : (r_last_y - r_gy);

    // axis muxes for the shared divide and clamp
    assign w_sel_g     = (w_uword.axis == tpef_pkg::AXIS_Y) ? r_gy : r_gx;
    assign w_sel_off   = (w_uword.axis == tpef_pkg::AXIS_Y) ? r_offset_y : r_offset_x;
    assign w_sel_scale = (w_uword.axis == tpef_pkg::AXIS_Y) ? r_scale_y : r_scale_x;
    assign w_sel_size  = (w_uword.axis == tpef_pkg::AXIS_Y) ? r_height : r_width;
    assign w_sel_move  = (w_uword.axis == tpef_pkg::AXIS_Y) ? r_move_y : r_move_x;
    assign w_dividend  = (w_sel_g > w_sel_off) ? (w_sel_g - w_sel_off) : '0;

    always_comb begin
        if (w_sel_size == '0) begin
            w_size_eff = tpef_pkg::SIZE_W'(1);
        end else if (w_sel_size > tpef_pkg::SIZE_MAX) begin
            w_size_eff = tpef_pkg::SIZE_MAX;
        end else begin
            w_size_eff = w_sel_size;
        end
    end

    assign w_top     = tpef_pkg::COORD_W'(w_size_eff - tpef_pkg::SIZE_W'(1));
    assign w_clamped = (w_quotient > tpef_pkg::SUM_W'(w_top)) ?
                       w_top : w_quotient[tpef_pkg::COORD_W-1:0];
    // mirror the axis
    assign w_coord   = w_top - w_clamped;

    tpef_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_sel_scale),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // sequencer: one control word per step
    always_comb begin
        n_pc        = r_pc;
        n_cnt       = r_cnt;
        n_sum_x     = r_sum_x;
        n_sum_y     = r_sum_y;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_held_x    = r_held_x;
        n_held_y    = r_held_y;
        n_touching  = r_touching;
        n_move_x    = r_move_x;
        n_move_y    = r_move_y;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        w_div_start = 1'b0;
        w_emit_load = 1'b0;

        case (w_uword.op)
            tpef_pkg::OP_WAIT: begin
                if (w_in_acc) begin
                    if (i_in_data.pen_lifted) begin
                        n_cnt   = '0;
                        n_sum_x = '0;
                        n_sum_y = '0;
                        if (r_touching) begin
                            n_touching  = 1'b0;
                            n_out_valid = 1'b1;
                            n_out_data  = '{event_kind: tpef_pkg::EV_UP,
                                            point_x: r_held_x, point_y: r_held_y};
                        end
                    end else if (r_cnt == tpef_pkg::CNT_LAST) begin
                        // group complete: latch sums, restart accumulation
                        n_gx    = w_acc_x;
                        n_gy    = w_acc_y;
                        n_cnt   = '0;
                        n_sum_x = '0;
                        n_sum_y = '0;
                        n_pc    = r_pc + 1'b1;
                    end else begin
                        n_sum_x = w_acc_x;
                        n_sum_y = w_acc_y;
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
            end
            tpef_pkg::OP_CMP: begin
                n_move_x = !r_touching || (w_dx > r_tol_x);
                n_move_y = !r_touching || (w_dy > r_tol_y);
                if (!n_move_x && !n_move_y) begin
                    n_pc = w_uword.jmp;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            tpef_pkg::OP_START: begin
                if (w_sel_move) begin
                    w_div_start = 1'b1;
                    n_pc        = r_pc + 1'b1;
                end else begin
                    n_pc = w_uword.jmp;
                end
            end
            tpef_pkg::OP_FINISH: begin
                if (w_div_stat.done) begin
                    if (w_uword.axis == tpef_pkg::AXIS_Y) begin
                        n_held_y = w_coord;
                        n_last_y = r_gy;
                    end else begin
                        n_held_x = w_coord;
                        n_last_x = r_gx;
                    end
                    n_pc = r_pc + 1'b1;
                end else begin
                    n_pc = w_uword.jmp;
                end
            end
            tpef_pkg::OP_EMIT: begin
                // hold until the output register frees
                if (w_out_free) begin
                    w_emit_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = '{event_kind: r_touching ? tpef_pkg::EV_DRAG
                                                           : tpef_pkg::EV_DOWN,
                                    point_x: r_held_x, point_y: r_held_y};
                    n_touching  = 1'b1;
                    n_pc        = w_uword.jmp;
                end
            end
            default: begin
                n_pc = tpef_pkg::STEP_WAIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= tpef_pkg::STEP_WAIT;
            r_cnt       <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_touching  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_held_x    <= n_held_x;
            r_held_y    <= n_held_y;
            r_touching  <= n_touching;
            r_out_valid <= n_out_valid;
        end
        r_gx       <= n_gx;
        r_gy       <= n_gy;
        r_move_x   <= n_move_x;
        r_move_y   <= n_move_y;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `TPEF_ASSERT_NOW(a_div_done_in_finish, i_clk, i_rst_n, w_div_stat.done, w_uword.op == tpef_pkg::OP_FINISH, "divider finished outside a finish step")
    `TPEF_ASSERT_NOW(a_emit_needs_move, i_clk, i_rst_n, r_pc == tpef_pkg::STEP_EMIT, r_move_x || r_move_y, "emit step reached with no moved axis")
    `TPEF_ASSERT_NEXT(a_group_close, i_clk, i_rst_n, w_in_acc && !i_in_data.pen_lifted && (r_cnt == tpef_pkg::CNT_LAST), (r_pc == tpef_pkg::STEP_CMP) && (r_cnt == '0) && (r_sum_x == '0), "group close did not restart accumulation")
    `TPEF_ASSERT_NEXT(a_emit_sets_touch, i_clk, i_rst_n, w_emit_load, r_touching && o_out_valid && (r_pc == tpef_pkg::STEP_WAIT), "pen event did not mark the pen down")

endmodule

// ===== test/touch_point_event_filter_checker.sv =====
// Scoreboard for the touch point event filter: watches the sample, event and register
// channels, predicts each event from its own copy of the filter state, compares fields.
// Depends on tpef_pkg.
`timescale 1ns / 1ps

module touch_point_event_filter_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  tpef_pkg::t_in_item             i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  tpef_pkg::t_out_item            i_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tpef_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tpef_pkg::SUM_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import tpef_pkg::*;

    // Register copies
    logic [SCALE_W-1:0] div_x, div_y;
    logic [SUM_W-1:0]   edge_x, edge_y;
    logic [SUM_W-1:0]   deadband_x, deadband_y;
    logic [SIZE_W-1:0]  width_px, height_px;

    // Filter state
    int unsigned        pair_cnt;
    logic [SUM_W-1:0]   acc_x, acc_y;
    bit                 pen_down;
    logic [SUM_W-1:0]   ref_x, ref_y;
    logic [COORD_W-1:0] pos_x, pos_y;

    t_out_item pending_events[$];
    int        fail_tally;
    int        checked_tally;

    function automatic logic [SUM_W-1:0] sum_distance(input logic [SUM_W-1:0] a, b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [COORD_W-1:0] screen_coord(input logic [SUM_W-1:0] raw, offs,
                                                        input logic [SCALE_W-1:0] div,
                                                        input logic [SIZE_W-1:0] size);
        logic [SUM_W-1:0]   excess;
        logic [SCALE_W-1:0] divisor;
        logic [SIZE_W-1:0]  span;
        excess  = (raw > offs) ? raw - offs : '0;
        divisor = (div == '0) ? SCALE_W'(1) : div;
        span    = (size == '0) ? SIZE_W'(1) : ((size > SIZE_MAX) ? SIZE_MAX : size);
        span    = span - 1'b1;
        excess  = excess / divisor;
        if (excess > SUM_W'(span)) excess = SUM_W'(span);
        // mirror the axis
        return COORD_W'(span - excess[SIZE_W-1:0]);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t ns: %s got %0d, predicted %0d", $time, what, got, want);
        fail_tally++;
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] data);
        case (idx)
            REG_SCALE_X:  div_x      = data[SCALE_W-1:0];
            REG_OFFSET_X: edge_x     = data;
            REG_SCALE_Y:  div_y      = data[SCALE_W-1:0];
            REG_OFFSET_Y: edge_y     = data;
            REG_TOL_X:    deadband_x = data;
            REG_TOL_Y:    deadband_y = data;
            REG_WIDTH:    width_px   = data[SIZE_W-1:0];
            REG_HEIGHT:   height_px  = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic filter_sample(input t_in_item item);
        t_out_item        ev;
        logic [SUM_W-1:0] gx, gy;
        bit               mx, my;
        if (item.pen_lifted) begin
            pair_cnt = 0;
            acc_x    = '0;
            acc_y    = '0;
            if (pen_down) begin
                pen_down      = 1'b0;
                ev.event_kind = EV_UP;
                ev.point_x    = pos_x;
                ev.point_y    = pos_y;
                pending_events.push_back(ev);
            end
        end else begin
            acc_x = acc_x + SUM_W'(item.sample_x);
            acc_y = acc_y + SUM_W'(item.sample_y);
            pair_cnt++;
            if (pair_cnt == SAMPLES_PER_POINT) begin
                gx       = acc_x;
                gy       = acc_y;
                pair_cnt = 0;
                acc_x    = '0;
                acc_y    = '0;
                mx = !pen_down || (sum_distance(gx, ref_x) > deadband_x);
                my = !pen_down || (sum_distance(gy, ref_y) > deadband_y);
                // recalibrate only the axes that moved
                if (mx || my) begin
                    if (mx) begin
                        ref_x = gx;
                        pos_x = screen_coord(gx, edge_x, div_x, width_px);
                    end
                    if (my) begin
                        ref_y = gy;
                        pos_y = screen_coord(gy, edge_y, div_y, height_px);
                    end
                    ev.event_kind = pen_down ? EV_DRAG : EV_DOWN;
                    ev.point_x    = pos_x;
                    ev.point_y    = pos_y;
                    pending_events.push_back(ev);
                    pen_down = 1'b1;
                end
            end
        end
    endtask

    task automatic check_event(input t_out_item got);
        t_out_item want;
        if (pending_events.size() == 0) begin
            report_mismatch("event with none predicted, kind", int'(got.event_kind), -1);
        end else begin
            want = pending_events.pop_front();
            checked_tally++;
            if (got.event_kind !== want.event_kind)
                report_mismatch("event_kind", int'(got.event_kind), int'(want.event_kind));
            if (got.point_x !== want.point_x)
                report_mismatch("point_x", int'(got.point_x), int'(want.point_x));
            if (got.point_y !== want.point_y)
                report_mismatch("point_y", int'(got.point_y), int'(want.point_y));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            div_x         = RST_SCALE_X;
            edge_x        = RST_OFFSET_X;
            div_y         = RST_SCALE_Y;
            edge_y        = RST_OFFSET_Y;
            deadband_x    = RST_TOL_X;
            deadband_y    = RST_TOL_Y;
            width_px      = RST_WIDTH;
            height_px     = RST_HEIGHT;
            pair_cnt      = 0;
            acc_x         = '0;
            acc_y         = '0;
            pen_down      = 1'b0;
            ref_x         = '0;
            ref_y         = '0;
            pos_x         = '0;
            pos_y         = '0;
            fail_tally    = 0;
            checked_tally = 0;
            pending_events.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_setting(i_cfg_index, i_cfg_data);
            if (i_out_valid && !i_out_stall) check_event(i_out_data);
            if (i_in_valid && !i_in_stall) filter_sample(i_in_data);
        end
        o_pending    <= pending_events.size();
        o_fail_count <= fail_tally;
        o_checked    <= checked_tally;
    end

endmodule

// ===== test/touch_point_event_filter_unit_test.sv =====
// Testbench top for touch_point_event_filter_unit: clock, reset, sample and register
// stimulus, output stall pattern and the final verdict.
// Depends on tpef_pkg, the filter RTL and touch_point_event_filter_checker.
`timescale 1ns / 1ps

module touch_point_event_filter_unit_test;
    import tpef_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 100;
    localparam int RANDOM_PHASES = 5;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SUM_W-1:0]     i_cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned items_sent    = 0;
    int unsigned cfg_writes    = 0;
    int unsigned settings_used = 1;
    bit          quiet         = 1'b0;
    bit          burst_mode    = 1'b0;
    bit          hold_go       = 1'b0;

    touch_point_event_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    touch_point_event_filter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Event receiver: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        int unsigned run_left;
        run_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
                hold_go     = 1'b0;
            end else if (quiet) begin
                i_out_stall = 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall = 1'b1;
                run_left    = $urandom_range(0, 8);
            end else begin
                i_out_stall = 1'b0;
                run_left    = $urandom_range(0, 15);
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] clip_sample(input int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'hFFF;
        return SAMPLE_W'(v);
    endfunction

    function automatic t_in_item sample_pair(input int x, input int y);
        t_in_item it;
        it.pen_lifted = 1'b0;
        it.sample_x   = clip_sample(x);
        it.sample_y   = clip_sample(y);
        return it;
    endfunction

    function automatic t_in_item pen_up_item();
        t_in_item it;
        it.pen_lifted = 1'b1;
        it.sample_x   = SAMPLE_W'($urandom);
        it.sample_y   = SAMPLE_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_in_item item);
        int unsigned gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        if (!quiet && !burst_mode && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_in_data  = $bits(t_in_item)'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // One full group around (x, y); the first pair carries an extra bump.
    task automatic send_group(input int x, input int y, input int jit,
                              input int bump_x, input int bump_y);
        int dx, dy;
        for (int k = 0; k < SAMPLES_PER_POINT; k++) begin
            dx = int'($urandom_range(0, 2 * jit)) - jit;
            dy = int'($urandom_range(0, 2 * jit)) - jit;
            if (k == 0) begin
                dx += bump_x;
                dy += bump_y;
            end
            send_item(sample_pair(x + dx, y + dy));
        end
    endtask

    task automatic wait_for_events();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Let a silent group finish its compare before the block is touched again.
    task automatic settle();
        wait_for_events();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = SUM_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input int unsigned sx, ox, sy, oy, tx, ty, w, h);
        write_reg(REG_SCALE_X, sx);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_SCALE_Y, sy);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_TOL_X, tx);
        write_reg(REG_TOL_Y, ty);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        settings_used++;
    endtask

    task automatic random_settings(input bit raw);
        if (raw) begin
            write_all($urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end else begin
            write_all($urandom_range(1, 400), $urandom_range(0, 9000),
                      $urandom_range(1, 400), $urandom_range(0, 9000),
                      $urandom_range(0, 3000), $urandom_range(0, 3000),
                      $urandom_range(1, 4096), $urandom_range(1, 4096));
        end
    endtask

    // Mostly strokes: groups around a wandering point closed by a pen-up,
    // with bursts of raw noise, broken groups and stray pen-ups.
    task automatic run_strokes(input int unsigned budget);
        int unsigned start, groups, kind, n;
        int          cx, cy;
        start = items_sent;
        while (items_sent - start < budget) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                cx     = $urandom_range(0, 4095);
                cy     = $urandom_range(0, 4095);
                groups = $urandom_range(1, 5);
                repeat (groups) begin
                    if ($urandom_range(0, 2) == 0) begin
                        cx = int'(clip_sample(cx + int'($urandom_range(0, 600)) - 300));
                        cy = int'(clip_sample(cy + int'($urandom_range(0, 600)) - 300));
                    end
                    send_group(cx, cy, $urandom_range(0, 40), 0, 0);
                end
                if ($urandom_range(0, 7) != 0) send_item(pen_up_item());
            end else if (kind == 7) begin
                n = $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(0, 9) == 0) send_item(pen_up_item());
                    else send_item(sample_pair($urandom_range(0, 4095), $urandom_range(0, 4095)));
                end
            end else if (kind == 8) begin
                n = $urandom_range(1, SAMPLES_PER_POINT - 1);
                repeat (n) send_item(sample_pair($urandom_range(0, 4095), $urandom_range(0, 4095)));
                send_item(pen_up_item());
            end else begin
                send_item(pen_up_item());
            end
            if ($urandom_range(0, 15) == 0) wait_for_events();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: stray pen-up, clamps at both edges, no movement, pen-up mid group
        send_item(pen_up_item());
        send_group(0, 0, 0, 0, 0);
        send_group(4095, 4095, 0, 0, 0);
        send_group(4095, 4095, 0, 0, 0);
        repeat (10) send_item(sample_pair(1234, 3210));
        send_item(pen_up_item());
        send_item(pen_up_item());
        send_group(12'hAAA, 12'h555, 0, 0, 0);
        send_group(12'h555, 12'h555, 0, 0, 0);
        send_group(12'h555, 12'h557, 0, 0, 0);
        send_item(pen_up_item());
        settle();

        // Low extremes: zero scale, zero offset and tolerance, zero-width screen
        write_all(0, 0, 0, 0, 0, 0, 0, 1);
        send_group(0, 0, 0, 0, 0);
        send_group(1, 1, 0, 0, 0);
        send_group(1, 1, 0, 0, 0);
        send_item(pen_up_item());
        settle();

        // High extremes: masked scale, oversized screen, tolerance never exceeded
        write_all('h1FFFF, 'h1FFFF, 'h1FFFF, 'h1FFFF, 'h1FFFF, 'h1FFFF,
                  'h1FFF, 5000);
        send_group(4095, 4095, 0, 0, 0);
        send_group(0, 0, 0, 0, 0);
        send_item(pen_up_item());
        send_group(0, 0, 0, 0, 0);
        send_item(pen_up_item());
        settle();

        // Tolerance boundary: a change equal to it holds, one more moves that axis only
        write_all(32, 0, 32, 0, 32, 32, 4096, 4096);
        send_group(100, 100, 0, 0, 0);
        send_group(100, 100, 0, 32, 0);
        send_group(100, 100, 0, 33, 0);
        send_group(100, 100, 0, 33, -33);
        send_item(pen_up_item());
        settle();

        // Back-to-back groups against a held receiver so the block backs up
        hold_go    = 1'b1;
        burst_mode = 1'b1;
        repeat (4) send_group(2048, 2048, 2047, 0, 0);
        burst_mode = 1'b0;
        send_item(pen_up_item());
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_settings(p == 2);
            if (p == RANDOM_PHASES - 1) quiet = 1'b1;
            run_strokes(PHASE_ITEMS);
            settle();
        end

        $display("Checked %0d pen events from %0d sample and pen-up transfers",
                 checked, items_sent);
        $display("Register settings: %0d over %0d writes, one long output hold-off",
                 settings_used, cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
